### rtl/core/urlap_pkg.sv
// Shared types and constants for the URL authority parser.
// Used by urlap_front, urlap_back and url_authority_parser_core.
`default_nettype none

package urlap_pkg;

  localparam int unsigned DefMaxUrlLen = 4096;
  localparam int unsigned FieldW       = 13;
  localparam int unsigned PortW        = 16;
  localparam int unsigned PortMax      = 65535;

  // Depth of the queue between the front and the back.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChSlash = 8'h2f;
  localparam logic [7:0] ChLbr   = 8'h5b;
  localparam logic [7:0] ChRbr   = 8'h5d;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  typedef enum logic [2:0] {
    CLS_OTHER = 3'd0,
    CLS_DIGIT = 3'd1,
    CLS_COLON = 3'd2,
    CLS_SLASH = 3'd3,
    CLS_LBR   = 3'd4,
    CLS_RBR   = 3'd5
  } char_class_e;

  typedef enum logic [3:0] {
    STS_OK           = 4'd0,
    STS_EMPTY        = 4'd1,
    STS_NO_SEP       = 4'd2,
    STS_EMPTY_SCHEME = 4'd3,
    STS_NO_HOST      = 4'd4,
    STS_NO_BRACKET   = 4'd5,
    STS_BAD_PORT     = 4'd6,
    STS_PORT_RANGE   = 4'd7,
    STS_EMPTY_HOST   = 4'd8,
    STS_TOO_LONG     = 4'd9
  } status_e;

  // One classified beat as it travels through the queue.
  typedef struct packed {
    char_class_e cls;
    logic [3:0]  digit;
    logic        present;
    logic        last;
  } q_item_t;

  typedef struct packed {
    status_e             status;
    logic [FieldW-1:0]   scheme_len;
    logic [FieldW-1:0]   host_offset;
    logic [FieldW-1:0]   host_len;
    logic                port_flag;
    logic [PortW-1:0]    port_value;
    logic [FieldW-1:0]   path_offset;
    logic [FieldW-1:0]   path_len;
  } result_t;

  // Reduces a widened offset or length to the reported field width.
  function automatic logic [FieldW-1:0] to_field(logic [31:0] v);
    return v[FieldW-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/core/urlap_front.sv
// Front end of the URL authority parser: classifies each input beat and
// holds it in a short queue for the back end. Depends on urlap_pkg.
`default_nettype none

module urlap_front import urlap_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       byte_present_i,
  input  wire logic       last_i,
  output logic            q_valid_o,
  output q_item_t         q_item_o,
  input  wire logic       q_pop_i
);

  q_item_t             item;
  q_item_t             entries_q [QDepth];
  logic [QPtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]    count_q, count_d;
  logic                push;
  logic                pop;

  always_comb begin
    item.present = byte_present_i;
    item.last    = last_i;
    item.digit   = in_byte_i[3:0];
    if (in_byte_i == ChColon) begin
      item.cls = CLS_COLON;
    end else if (in_byte_i == ChSlash) begin
      item.cls = CLS_SLASH;
    end else if (in_byte_i == ChLbr) begin
      item.cls = CLS_LBR;
    end else if (in_byte_i == ChRbr) begin
      item.cls = CLS_RBR;
    end else if (in_byte_i >= ChZero && in_byte_i <= ChNine) begin
      item.cls = CLS_DIGIT;
    end else begin
      item.cls = CLS_OTHER;
    end
  end

  assign in_stall_o = (count_q == QCntW'(QDepth));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (count_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= item;
    end
  end

endmodule

`default_nettype wire

### rtl/core/urlap_back.sv
// Back end of the URL authority parser: runs the parse state over the
// queued beats and registers one result per URL. Depends on urlap_pkg.
`default_nettype none

module urlap_back import urlap_pkg::*; #(
  parameter int unsigned MAX_URL_LEN = DefMaxUrlLen
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    q_valid_i,
  input  wire q_item_t q_item_i,
  output logic         q_pop_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output result_t      result_o
);

  localparam int unsigned PosW = $clog2(MAX_URL_LEN + 2);

  typedef enum logic [7:0] {
    PH_SCHEME     = 8'b0000_0001,
    PH_HOST_FIRST = 8'b0000_0010,
    PH_PLAIN      = 8'b0000_0100,
    PH_BRACKET    = 8'b0000_1000,
    PH_AFTER_BR   = 8'b0001_0000,
    PH_BPORT      = 8'b0010_0000,
    PH_BIGNORE    = 8'b0100_0000,
    PH_PATH       = 8'b1000_0000
  } phase_e;

  typedef enum logic [1:0] {
    PF_NONE  = 2'd0,
    PF_BAD   = 2'd1,
    PF_RANGE = 2'd2
  } port_fault_e;

  phase_e            phase_q, phase_d;
  port_fault_e       fault_q, fault_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [PosW-1:0]   scheme_len_q, scheme_len_d;
  logic [PosW-1:0]   host_begin_q, host_begin_d;
  logic [PosW-1:0]   host_stop_q, host_stop_d;
  logic [PosW-1:0]   path_begin_q, path_begin_d;
  logic [PortW-1:0]  accum_q, accum_d;
  logic              last_colon_q, last_colon_d;
  logic              colon_slash_q, colon_slash_d;
  logic              colon_seen_q, colon_seen_d;
  logic              bracketed_q, bracketed_d;
  logic              closed_q, closed_d;

  logic              out_valid_q, out_valid_d;
  result_t           result_q, result_d;

  logic              take;
  logic              finish;
  logic              is_slash;
  logic              do_digit;
  logic [19:0]       port_next;
  logic [PosW-1:0]   host_limit;
  logic [PosW-1:0]   host_off;
  logic [PosW-1:0]   host_len;

  // A beat that ends a URL waits in the queue while the result register is busy.
  assign q_pop_o  = q_valid_i && (!q_item_i.last || !out_valid_q || !out_stall_i);
  assign finish   = q_pop_o && q_item_i.last;
  assign take     = q_pop_o && q_item_i.present && (pos_q < PosW'(MAX_URL_LEN));
  assign is_slash = (q_item_i.cls == CLS_SLASH);
  assign port_next = {1'b0, accum_q, 3'b000} + {3'b000, accum_q, 1'b0} +
                     {16'd0, q_item_i.digit};

  always_comb begin
    phase_d       = phase_q;
    fault_d       = fault_q;
    pos_d         = pos_q;
    scheme_len_d  = scheme_len_q;
    host_begin_d  = host_begin_q;
    host_stop_d   = host_stop_q;
    path_begin_d  = path_begin_q;
    accum_d       = accum_q;
    last_colon_d  = last_colon_q;
    colon_slash_d = colon_slash_q;
    colon_seen_d  = colon_seen_q;
    bracketed_d   = bracketed_q;
    closed_d      = closed_q;
    do_digit      = 1'b0;

    if (q_pop_o && q_item_i.present) begin
      pos_d = take ? pos_q + 1'b1 : PosW'(MAX_URL_LEN + 1);
    end

    if (take) begin
      unique case (phase_q)
        PH_SCHEME: begin
          if (is_slash && colon_slash_q) begin
            scheme_len_d = pos_q - PosW'(2);
            host_begin_d = pos_q + 1'b1;
            phase_d      = PH_HOST_FIRST;
          end
          colon_slash_d = is_slash && last_colon_q;
          last_colon_d  = (q_item_i.cls == CLS_COLON);
        end
        PH_HOST_FIRST, PH_PLAIN: begin
          // The first host byte that is neither '/' nor '[' is parsed as plain host text.
          if (is_slash) begin
            path_begin_d = pos_q;
            phase_d      = PH_PATH;
          end else if (phase_q == PH_HOST_FIRST && q_item_i.cls == CLS_LBR) begin
            bracketed_d = 1'b1;
            phase_d     = PH_BRACKET;
          end else begin
            phase_d = PH_PLAIN;
            if (q_item_i.cls == CLS_COLON) begin
              colon_seen_d = 1'b1;
              host_stop_d  = pos_q;
              accum_d      = '0;
              fault_d      = PF_NONE;
            end else begin
              do_digit = colon_seen_q;
            end
          end
        end
        PH_BRACKET: begin
          if (is_slash) begin
            path_begin_d = pos_q;
            phase_d      = PH_PATH;
          end else if (q_item_i.cls == CLS_RBR) begin
            closed_d    = 1'b1;
            host_stop_d = pos_q;
            phase_d     = PH_AFTER_BR;
          end
        end
        PH_AFTER_BR: begin
          if (is_slash) begin
            path_begin_d = pos_q;
            phase_d      = PH_PATH;
          end else if (q_item_i.cls == CLS_COLON) begin
            colon_seen_d = 1'b1;
            phase_d      = PH_BPORT;
          end else begin
            phase_d = PH_BIGNORE;
          end
        end
        PH_BPORT: begin
          if (is_slash) begin
            path_begin_d = pos_q;
            phase_d      = PH_PATH;
          end else begin
            do_digit = 1'b1;
          end
        end
        PH_BIGNORE: begin
          if (is_slash) begin
            path_begin_d = pos_q;
            phase_d      = PH_PATH;
          end
        end
        PH_PATH: begin
        end
        default: begin
        end
      endcase
    end

    // Only the first port fault since the most recent port colon is kept.
    if (do_digit && fault_q == PF_NONE) begin
      if (q_item_i.cls != CLS_DIGIT) begin
        fault_d = PF_BAD;
      end else if (port_next > 20'(PortMax)) begin
        fault_d = PF_RANGE;
      end else begin
        accum_d = port_next[PortW-1:0];
      end
    end
  end

  // The result is formed from the state after the final beat has been applied.
  always_comb begin
    host_limit = (phase_d == PH_PATH) ? path_begin_d : pos_d;
    if (bracketed_d) begin
      host_off = host_begin_d + 1'b1;
      host_len = host_stop_d - host_off;
    end else begin
      host_off = host_begin_d;
      host_len = (colon_seen_d ? host_stop_d : host_limit) - host_begin_d;
    end

    result_d = '0;
    priority if (pos_d == '0) begin
      result_d.status = STS_EMPTY;
    end else if (pos_d > PosW'(MAX_URL_LEN)) begin
      result_d.status = STS_TOO_LONG;
    end else if (phase_d == PH_SCHEME) begin
      result_d.status = STS_NO_SEP;
    end else if (scheme_len_d == '0) begin
      result_d.status = STS_EMPTY_SCHEME;
    end else if (phase_d == PH_HOST_FIRST) begin
      result_d.status = STS_NO_HOST;
    end else if (bracketed_d && !closed_d) begin
      result_d.status = STS_NO_BRACKET;
    end else if (colon_seen_d && fault_d == PF_BAD) begin
      result_d.status = STS_BAD_PORT;
    end else if (colon_seen_d && fault_d == PF_RANGE) begin
      result_d.status = STS_PORT_RANGE;
    end else if (host_len == '0) begin
      result_d.status = STS_EMPTY_HOST;
    end else begin
      result_d.status      = STS_OK;
      result_d.scheme_len  = to_field(32'(scheme_len_d));
      result_d.host_offset = to_field(32'(host_off));
      result_d.host_len    = to_field(32'(host_len));
      result_d.port_flag   = colon_seen_d;
      result_d.port_value  = colon_seen_d ? accum_d : '0;
      result_d.path_offset = to_field(32'(host_limit));
      result_d.path_len    = to_field(32'(pos_d - host_limit));
    end
  end

  always_comb begin
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_SCHEME;
      fault_q       <= PF_NONE;
      pos_q         <= '0;
      scheme_len_q  <= '0;
      host_begin_q  <= '0;
      host_stop_q   <= '0;
      path_begin_q  <= '0;
      accum_q       <= '0;
      last_colon_q  <= 1'b0;
      colon_slash_q <= 1'b0;
      colon_seen_q  <= 1'b0;
      bracketed_q   <= 1'b0;
      closed_q      <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (finish) begin
        phase_q       <= PH_SCHEME;
        fault_q       <= PF_NONE;
        pos_q         <= '0;
        scheme_len_q  <= '0;
        host_begin_q  <= '0;
        host_stop_q   <= '0;
        path_begin_q  <= '0;
        accum_q       <= '0;
        last_colon_q  <= 1'b0;
        colon_slash_q <= 1'b0;
        colon_seen_q  <= 1'b0;
        bracketed_q   <= 1'b0;
        closed_q      <= 1'b0;
      end else begin
        phase_q       <= phase_d;
        fault_q       <= fault_d;
        pos_q         <= pos_d;
        scheme_len_q  <= scheme_len_d;
        host_begin_q  <= host_begin_d;
        host_stop_q   <= host_stop_d;
        path_begin_q  <= path_begin_d;
        accum_q       <= accum_d;
        last_colon_q  <= last_colon_d;
        colon_slash_q <= colon_slash_d;
        colon_seen_q  <= colon_seen_d;
        bracketed_q   <= bracketed_d;
        closed_q      <= closed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

`default_nettype wire

### rtl/core/url_authority_parser_core.sv
// URL authority parser, one URL character per beat on the input channel.
// Each beat carries in_byte_i, byte_present_i and last_i; a beat with
// byte_present_i low adds no character and only matters when last_i is high.
// The output channel gives one beat per URL, on the beat that carries last_i:
// a status code, the scheme length, the host and path offsets and lengths, and the port flag and value.
// Both channels move a beat at a clock edge where valid is high and stall low.
// Throughput is one input beat per cycle while in_stall_o is low; the parse
// state advances by one character per cycle in the back end while beats wait
// in the queue and no final beat is held back. out_valid_o rises once a URL's
// final beat is accepted: the beat is held in the front queue, and the parse
// step then loads the result register that drives the output channel.
// While the receiver stalls, the result holds and input beats keep filling the
// two-entry queue; in_stall_o rises only when that queue is full and the next
// URL's final beat is waiting behind the held result.
// Reset empties the queue, clears the parse state and drops any pending result.
// Characters past MAX_URL_LEN are counted as one overflow and give status 9.
`default_nettype none

module url_authority_parser_core import urlap_pkg::*; #(
  parameter int unsigned MAX_URL_LEN = DefMaxUrlLen
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [7:0]        in_byte_i,
  input  wire logic              byte_present_i,
  input  wire logic              last_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [3:0]             status_o,
  output logic [FieldW-1:0]      scheme_len_o,
  output logic [FieldW-1:0]      host_offset_o,
  output logic [FieldW-1:0]      host_len_o,
  output logic                   port_flag_o,
  output logic [PortW-1:0]       port_value_o,
  output logic [FieldW-1:0]      path_offset_o,
  output logic [FieldW-1:0]      path_len_o
);

  logic    q_valid;
  q_item_t q_item;
  logic    q_pop;
  result_t result;

  urlap_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_byte_i      (in_byte_i),
    .byte_present_i (byte_present_i),
    .last_i         (last_i),
    .q_valid_o      (q_valid),
    .q_item_o       (q_item),
    .q_pop_i        (q_pop)
  );

  urlap_back #(
    .MAX_URL_LEN (MAX_URL_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result)
  );

  assign status_o      = result.status;
  assign scheme_len_o  = result.scheme_len;
  assign host_offset_o = result.host_offset;
  assign host_len_o    = result.host_len;
  assign port_flag_o   = result.port_flag;
  assign port_value_o  = result.port_value;
  assign path_offset_o = result.path_offset;
  assign path_len_o    = result.path_len;

endmodule

`default_nettype wire
